FILE: src/first_fit_range_allocator_assert.svh
// Assertion macros for the first-fit range allocator.
// Used by the top level only; no other dependencies.
`ifndef FIRST_FIT_RANGE_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_ASSERT_SVH

// implication checked every clock outside reset
`define FFRA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ffra check failed");

// next-cycle implication
`define FFRA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ffra check failed");

`endif

FILE: src/ffra_pkg.sv
// Shared types and constants for the first-fit range allocator.
// No dependencies.
package ffra_pkg;

  localparam int MaxSpans = 16;
  localparam int AddrBits = 20;
  localparam int SizeBits = AddrBits + 1;
  localparam int IdxBits  = $clog2(MaxSpans);
  localparam int CntBits  = $clog2(MaxSpans + 1);

  typedef logic [AddrBits-1:0] addr_t;
  typedef logic [SizeBits-1:0] size_t;
  typedef logic [IdxBits-1:0]  idx_t;
  typedef logic [CntBits-1:0]  cnt_t;

  localparam size_t CapLimit = size_t'(1) << AddrBits;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StNoFit = 2'd1;
  localparam logic [1:0] StFull  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT_DN,
    S_SHIFT_UP,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_SHRINK,
    ACT_REMOVE,
    ACT_MERGE_PREV,
    ACT_MERGE_BOTH,
    ACT_MERGE_NEXT,
    ACT_INSERT
  } act_t;

  typedef struct packed {
    logic start;
    logic load_cap;
    logic scan_step;
    logic apply;
    logic shift_dn;
    logic shift_up;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic shift_done;
    logic need_dn;
    logic need_up;
  } stat_t;

endpackage

FILE: src/first_fit_range_allocator.sv
// A request passes from idle through the scan, decide, optional shift (one entry
// per cycle) and done states; done waits until the output register is free.
// A new request is taken only back in idle; a finished result waits in the
// output register while the next request is taken.
// Reset (rst_n, synchronous): one free span [0, 2^20), free total 2^20.
// Capacity writes are taken only while idle.
`include "first_fit_range_allocator_assert.svh"
module first_fit_range_allocator import ffra_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [20:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // op, req_size, range_offset
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // status, grant_offset, grant_size, free_total
);

  cmd_t  cmd;
  stat_t stat;
  logic  res_load;
  logic  [1:0] r_st;
  addr_t r_goff;
  size_t r_gsize, r_free;
  logic  out_valid_r;
  logic [63:0] out_data_r;

  ffra_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .req_valid(in_tvalid), .cfg_valid(cfg_valid),
    .res_free(!out_valid_r || out_tready), .stat(stat), .cmd(cmd),
    .req_ready(in_tready), .cfg_ready(cfg_ready), .res_load(res_load)
  );

  ffra_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .cfg_cap(cfg_data),
    .req_op(in_tdata[0]), .req_size(in_tdata[21:1]), .req_off(in_tdata[41:22]),
    .stat(stat), .res_status(r_st), .res_goff(r_goff), .res_gsize(r_gsize),
    .res_free(r_free)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (res_load) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
    if (res_load) out_data_r <= {r_free, r_gsize, r_goff, r_st};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `FFRA_ASSERT_IMP(a_no_cfg_busy, !in_tready && !cfg_ready, !(in_tvalid && in_tready))
  `FFRA_ASSERT_NXT(a_load_valid, res_load, out_tvalid)
  `FFRA_ASSERT_IMP(a_status_range, out_tvalid, out_tdata[1:0] != 2'd3)

endmodule

FILE: src/ffra_ctrl.sv
// Controller FSM of the first-fit range allocator.
// Depends on ffra_pkg.
module ffra_ctrl import ffra_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  req_valid,
  input  logic  cfg_valid,
  input  logic  res_free,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  req_ready,
  output logic  cfg_ready,
  output logic  res_load
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    req_ready = 1'b0;
    cfg_ready = 1'b0;
    res_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cfg_ready = 1'b1;
        req_ready = !cfg_valid;
        if (cfg_valid) begin
          cmd.load_cap = 1'b1;
        end else if (req_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.need_dn)      state_nxt = S_SHIFT_DN;
        else if (stat.need_up) state_nxt = S_SHIFT_UP;
        else begin
          cmd.apply = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_SHIFT_DN: begin
        cmd.shift_dn = 1'b1;
        if (stat.shift_done) begin
          cmd.apply = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_SHIFT_UP: begin
        cmd.shift_up = 1'b1;
        if (stat.shift_done) begin
          cmd.apply = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: src/ffra_dp.sv
// Datapath of the first-fit range allocator: span table, scan, shift, update.
// Depends on ffra_pkg.
module ffra_dp import ffra_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  input  size_t      cfg_cap,
  input  logic       req_op,
  input  size_t      req_size,
  input  addr_t      req_off,
  output stat_t      stat,
  output logic [1:0] res_status,
  output addr_t      res_goff,
  output size_t      res_gsize,
  output size_t      res_free
);

  addr_t span_start_r  [MaxSpans];
  size_t span_length_r [MaxSpans];
  cnt_t  cnt_r;
  size_t free_r, cap_r;
  logic  op_r;
  size_t size_r;
  addr_t off_r;
  cnt_t  i_r, k_r;
  logic  nop_r;
  act_t  act_r;
  logic [1:0] st_r;
  addr_t goff_r;
  size_t gsize_r;
  addr_t prev_s_r;
  size_t prev_l_r;
  size_t next_l_r;

  idx_t  ii;
  addr_t cur_s;
  size_t cur_l;
  logic  at_end;
  size_t cap_sat, clip;
  logic [SizeBits:0] offsz, prev_end, sum;

  assign ii     = i_r[IdxBits-1:0];
  assign at_end = (i_r == cnt_r);
  assign cur_s  = span_start_r[ii];
  assign cur_l  = span_length_r[ii];
  assign cap_sat = (cfg_cap > CapLimit) ? CapLimit : cfg_cap;
  assign offsz  = {1'b0, size_t'(off_r)} + {1'b0, size_r};
  assign prev_end = {1'b0, size_t'(prev_s_r)} + {1'b0, prev_l_r};
  assign sum    = prev_end + {1'b0, size_r};

  always_comb begin
    stat = '0;
    if (op_r == OpAlloc) stat.scan_done = at_end || (cur_l >= size_r);
    else                 stat.scan_done = at_end || (cur_s >= off_r);
    if (nop_r) stat.scan_done = 1'b1;
    stat.need_dn   = (act_r == ACT_REMOVE || act_r == ACT_MERGE_BOTH)
                     && (k_r + cnt_t'(1) < cnt_r);
    stat.need_up   = (act_r == ACT_INSERT) && (k_r > i_r);
    stat.shift_done = (act_r == ACT_INSERT) ? (k_r - cnt_t'(1) <= i_r)
                                            : (k_r + cnt_t'(2) >= cnt_r);
  end

  // action chosen at end of scan, combinational from the scan position
  act_t  act_c;
  logic [1:0] st_c;
  always_comb begin
    act_c = ACT_NONE;
    st_c  = StOk;
    if (nop_r) begin
      act_c = ACT_NONE;
    end else if (op_r == OpAlloc) begin
      if (at_end) st_c = StNoFit;
      else if (size_r == '0) act_c = ACT_NONE;
      else if (cur_l == size_r) act_c = ACT_REMOVE;
      else act_c = ACT_SHRINK;
    end else begin
      if (i_r != '0 && prev_end == {1'b0, size_t'(off_r)}) begin
        if (!at_end && sum == {1'b0, size_t'(cur_s)}) act_c = ACT_MERGE_BOTH;
        else act_c = ACT_MERGE_PREV;
      end else if (!at_end && offsz == {1'b0, size_t'(cur_s)}) begin
        act_c = ACT_MERGE_NEXT;
      end else if (cnt_r >= cnt_t'(MaxSpans)) begin
        st_c = StFull;
      end else begin
        act_c = ACT_INSERT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= cnt_t'(1);
      free_r <= CapLimit;
      cap_r <= CapLimit;
      span_start_r[0] <= '0;
      span_length_r[0] <= CapLimit;
      act_r <= ACT_NONE;
    end else if (cmd.load_cap) begin
      cap_r <= cap_sat;
      free_r <= cap_sat;
      cnt_r <= (cap_sat == '0) ? '0 : cnt_t'(1);
      span_start_r[0] <= '0;
      span_length_r[0] <= cap_sat;
    end else if (cmd.start) begin
      op_r  <= req_op;
      off_r <= req_off;
      i_r   <= '0;
      act_r <= ACT_NONE;
      if (req_op == OpFree) begin
        nop_r <= (req_size == '0) || (size_t'(req_off) >= cap_r);
        size_r <= ({1'b0, size_t'(req_off)} + {1'b0, req_size} > {1'b0, cap_r})
                  ? cap_r - size_t'(req_off) : req_size;
      end else begin
        nop_r <= 1'b0;
        size_r <= req_size;
      end
    end else if (cmd.scan_step) begin
      if (!stat.scan_done) begin
        prev_s_r <= cur_s;
        prev_l_r <= cur_l;
        i_r <= i_r + cnt_t'(1);
      end else begin
        act_r <= act_c;
        st_r  <= st_c;
        next_l_r <= cur_l;
        goff_r <= (op_r == OpAlloc && st_c == StOk) ? cur_s : '0;
        gsize_r <= (op_r == OpAlloc && st_c == StOk) ? size_r : '0;
        k_r <= (act_c == ACT_INSERT) ? cnt_r :
               (act_c == ACT_MERGE_BOTH) ? i_r : i_r;
      end
    end else if (cmd.shift_dn || cmd.shift_up) begin
      if (cmd.shift_dn) begin
        span_start_r[k_r[IdxBits-1:0]]  <= span_start_r[IdxBits'(k_r + cnt_t'(1))];
        span_length_r[k_r[IdxBits-1:0]] <= span_length_r[IdxBits'(k_r + cnt_t'(1))];
        k_r <= k_r + cnt_t'(1);
      end else begin
        span_start_r[IdxBits'(k_r)]  <= span_start_r[IdxBits'(k_r - cnt_t'(1))];
        span_length_r[IdxBits'(k_r)] <= span_length_r[IdxBits'(k_r - cnt_t'(1))];
        k_r <= k_r - cnt_t'(1);
      end
    end
    if (rst_n && cmd.apply) begin
      unique case (act_r)
        ACT_SHRINK: begin
          span_start_r[ii]  <= cur_s + addr_t'(size_r);
          span_length_r[ii] <= cur_l - size_r;
          free_r <= (free_r > size_r) ? free_r - size_r : '0;
        end
        ACT_REMOVE: begin
          cnt_r <= cnt_r - cnt_t'(1);
          free_r <= (free_r > size_r) ? free_r - size_r : '0;
        end
        ACT_MERGE_PREV: begin
          span_length_r[IdxBits'(i_r - cnt_t'(1))] <= prev_l_r + size_r;
        end
        ACT_MERGE_BOTH: begin
          span_length_r[IdxBits'(i_r - cnt_t'(1))] <= prev_l_r + size_r + next_l_r;
          cnt_r <= cnt_r - cnt_t'(1);
        end
        ACT_MERGE_NEXT: begin
          span_start_r[ii]  <= off_r;
          span_length_r[ii] <= cur_l + size_r;
        end
        ACT_INSERT: begin
          span_start_r[ii]  <= off_r;
          span_length_r[ii] <= size_r;
          cnt_r <= cnt_r + cnt_t'(1);
        end
        default: ;
      endcase
      if (act_r == ACT_MERGE_PREV || act_r == ACT_MERGE_BOTH ||
          act_r == ACT_MERGE_NEXT || act_r == ACT_INSERT) begin
        free_r <= ({1'b0, free_r} + {1'b0, size_r} > {1'b0, {SizeBits{1'b1}}})
                  ? {SizeBits{1'b1}} : free_r + size_r;
      end
    end
  end

  assign res_status = st_r;
  assign res_goff   = goff_r;
  assign res_gsize  = gsize_r;
  assign res_free   = free_r;

endmodule
